FILE: src/sorted_set_table_top_assert.svh
// Assertion macros shared by the sorted set table.
`ifndef SORTED_SET_TABLE_TOP_ASSERT_SVH
`define SORTED_SET_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/sst_pkg.sv
package sst_pkg;

    // Store geometry.
    localparam int CAPACITY      = 16;
    localparam int ELEMENT_WIDTH = 32;
    localparam int COUNT_WIDTH   = $clog2(CAPACITY + 1);
    localparam int IDX_WIDTH     = $clog2(CAPACITY);

    // Stream payload widths.
    localparam int IN_DATA_WIDTH  = 40;
    localparam int OUT_DATA_WIDTH = 8;
    localparam int OP_WIDTH       = 2;
    localparam int VALUE_WIDTH    = 32;
    localparam int RES_CNT_WIDTH  = 5;

    typedef logic signed [ELEMENT_WIDTH-1:0] t_elem;
    typedef logic [COUNT_WIDTH-1:0]          t_count;

    // Operation codes.
    typedef enum logic [OP_WIDTH-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input item
        logic compare;  // register the per-entry compare results
        logic commit;   // update the store and the result
    } t_dp_cmd;

endpackage

FILE: src/sorted_set_table_top.sv
// Sorted set table: insert, remove or search one signed value per item.
// The result is registered after the compare and update states; update waits until the result slot is free.
// A new item is accepted only once the previous one has been committed, set by the compare-then-update sequence.
// The next item is accepted while the previous result waits to be taken.
// Reset (synchronous, active low) clears the element count and the handshake state;
// store contents are not cleared and are never read past the count.
`include "sorted_set_table_top_assert.svh"

module sorted_set_table_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Fields from bit 0: operation[1:0], value[33:2], zero fill[39:34].
    input  logic [sst_pkg::IN_DATA_WIDTH-1:0]     i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // Fields from bit 0: ok[0], full_res[1], count[6:2], empty_res[7].
    output logic [sst_pkg::OUT_DATA_WIDTH-1:0]    o_m_axis_tdata
);

    sst_pkg::t_dp_cmd w_cmd;
    logic             w_ok;
    logic             w_full_res;
    logic             w_empty_res;
    logic [sst_pkg::RES_CNT_WIDTH-1:0] w_count;

    sst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sst_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_operation (i_s_axis_tdata[sst_pkg::OP_WIDTH-1:0]),
        .i_value     (i_s_axis_tdata[sst_pkg::OP_WIDTH +: sst_pkg::VALUE_WIDTH]),
        .o_ok        (w_ok),
        .o_full_res  (w_full_res),
        .o_count     (w_count),
        .o_empty_res (w_empty_res)
    );

    assign o_m_axis_tdata = {w_empty_res, w_count, w_full_res, w_ok};

    // A refused insert never also reports success.
    `SST_ASSERT_SAME(a_ok_full_excl, o_m_axis_tvalid, !(w_ok && w_full_res))
    // The empty flag agrees with the reported count.
    `SST_ASSERT_SAME(a_empty_count, o_m_axis_tvalid, w_empty_res == (w_count == '0))
    // An accepted item keeps the block busy in the following cycle.
    `SST_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // A commit always leaves a result on the output.
    `SST_ASSERT_NEXT(a_commit_shows, w_cmd.commit, o_m_axis_tvalid)

endmodule

FILE: src/sst_ctrl.sv
module sst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sst_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_commit;

    // The result slot is free when empty or being taken this cycle.
    assign w_commit = (r_state == ST_UPD) && (!r_out_valid || i_out_ready);

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.compare = (r_state == ST_CMP);
    assign o_cmd.commit  = w_commit;

    // State and result-valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CMP;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_CMP: begin
                    r_state <= ST_UPD;
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_UPD: begin
                    if (w_commit) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/sst_datapath.sv
module sst_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sst_pkg::t_dp_cmd                     i_cmd,
    input  logic [sst_pkg::OP_WIDTH-1:0]         i_operation,
    input  logic signed [sst_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                                 o_ok,
    output logic                                 o_full_res,
    output logic [sst_pkg::RES_CNT_WIDTH-1:0]    o_count,
    output logic                                 o_empty_res
);

    sst_pkg::t_op    r_op;
    sst_pkg::t_elem  r_val;
    sst_pkg::t_count r_count;
    sst_pkg::t_count n_count;
    sst_pkg::t_elem  r_store [sst_pkg::CAPACITY];
    sst_pkg::t_elem  n_ins   [sst_pkg::CAPACITY];
    sst_pkg::t_elem  n_rem   [sst_pkg::CAPACITY];
    logic [sst_pkg::CAPACITY-1:0] r_lt;
    logic [sst_pkg::CAPACITY-1:0] r_eq;
    logic [sst_pkg::CAPACITY-1:0] w_lt_prev;
    logic r_ok;
    logic r_full;
    logic n_ok;
    logic n_full;
    logic w_present;
    logic w_is_full;
    logic w_do_ins;
    logic w_do_rem;

    // Capture the operation and the value, cast to the element type.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= sst_pkg::t_op'(i_operation);
            r_val <= sst_pkg::t_elem'(i_value);
        end
    end

    // One comparator per entry; entries past the count never match.
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            for (int i = 0; i < sst_pkg::CAPACITY; i++) begin
                r_lt[i] <= (sst_pkg::t_count'(i) < r_count) && (r_store[i] < r_val);
                r_eq[i] <= (sst_pkg::t_count'(i) < r_count) && (r_store[i] == r_val);
            end
        end
    end

    assign w_present = |r_eq;
    assign w_is_full = (r_count >= sst_pkg::t_count'(sst_pkg::CAPACITY));
    assign w_lt_prev = {r_lt[sst_pkg::CAPACITY-2:0], 1'b1};

    // Shifted store contents for insert and remove.
    always_comb begin
        for (int i = 0; i < sst_pkg::CAPACITY; i++) begin
            if (r_lt[i]) begin
                n_ins[i] = r_store[i];
                n_rem[i] = r_store[i];
            end else begin
                if (w_lt_prev[i]) begin
                    n_ins[i] = r_val;
                end else if (i > 0) begin
                    n_ins[i] = r_store[i-1];
                end else begin
                    n_ins[i] = r_val;
                end
                if (i < sst_pkg::CAPACITY - 1) begin
                    n_rem[i] = r_store[i+1];
                end else begin
                    n_rem[i] = r_store[i];
                end
            end
        end
    end

    // Outcome of the operation.
    always_comb begin
        n_ok     = 1'b0;
        n_full   = 1'b0;
        n_count  = r_count;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        unique case (r_op)
            sst_pkg::OP_INSERT: begin
                if (w_present) begin
                    n_ok = 1'b0;
                end else if (w_is_full) begin
                    n_full = 1'b1;
                end else begin
                    n_ok     = 1'b1;
                    w_do_ins = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            sst_pkg::OP_REMOVE: begin
                if (w_present) begin
                    n_ok     = 1'b1;
                    w_do_rem = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            sst_pkg::OP_SEARCH: begin
                n_ok = w_present;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Element count is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // Store row and result flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ok   <= n_ok;
            r_full <= n_full;
            if (w_do_ins) begin
                r_store <= n_ins;
            end else if (w_do_rem) begin
                r_store <= n_rem;
            end
        end
    end

    assign o_ok        = r_ok;
    assign o_full_res  = r_full;
    assign o_count     = sst_pkg::RES_CNT_WIDTH'(r_count);
    assign o_empty_res = (r_count == '0);

endmodule

FILE: verif/sorted_set_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the sorted set table, predicts every result
// from its own copy of the set and compares each result with the oldest prediction.
module sorted_set_checker
    import sst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    input  logic                      i_s_axis_tready,
    // Fields from bit 0: operation[1:0], value[33:2], zero fill[39:34].
    input  logic [IN_DATA_WIDTH-1:0]  i_s_axis_tdata,
    input  logic                      i_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // Fields from bit 0: ok[0], full_res[1], count[6:2], empty_res[7].
    input  logic [OUT_DATA_WIDTH-1:0] i_m_axis_tdata,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    // One result item, laid out as on the master side.
    typedef struct packed {
        logic                     empty_res;
        logic [RES_CNT_WIDTH-1:0] count;
        logic                     full_res;
        logic                     ok;
    } t_answer;

    // Model of the table: ascending entries below set_size.
    t_elem   set_entries [CAPACITY];
    int      set_size;
    t_answer expected_answers [$];
    int      fail_total;

    assign o_fail_count = fail_total;

    // Apply one operation to the modeled set and return the result it gives.
    function automatic t_answer apply_set_op(input logic [OP_WIDTH-1:0] op, input t_elem val);
        t_answer ans;
        int      pos;
        bit      present;
        ans = '0;
        pos = 0;
        while (pos < set_size && set_entries[pos] < val)
            pos++;
        present = 1'b0;
        if (pos < set_size)
            present = (set_entries[pos] == val);
        case (op)
            OP_INSERT: begin
                // The duplicate check wins over the capacity check.
                if (present) begin
                    ans.ok = 1'b0;
                end else if (set_size >= CAPACITY) begin
                    ans.full_res = 1'b1;
                end else begin
                    for (int j = set_size; j > pos; j--)
                        set_entries[j] = set_entries[j-1];
                    set_entries[pos] = val;
                    set_size++;
                    ans.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (present) begin
                    for (int j = pos; j + 1 < set_size; j++)
                        set_entries[j] = set_entries[j+1];
                    set_size--;
                    ans.ok = 1'b1;
                end
            end
            OP_SEARCH: begin
                ans.ok = present;
            end
            default: begin
                // The unused code leaves the set alone and answers not ok.
            end
        endcase
        ans.count     = set_size[RES_CNT_WIDTH-1:0];
        ans.empty_res = (set_size == 0);
        return ans;
    endfunction

    // Print one line per bad result and count it.
    task automatic report_mismatch(input string what, input t_answer got, input t_answer exp);
        $display("%0t ns: %s: got ok=%0b full=%0b count=%0d empty=%0b, ",
                 $time, what, got.ok, got.full_res, got.count, got.empty_res,
                 "expected ok=%0b full=%0b count=%0d empty=%0b",
                 exp.ok, exp.full_res, exp.count, exp.empty_res);
        fail_total++;
    endtask

    // Predict on each accepted input item, compare on each accepted result item.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer exp;
        string   bad_fields;
        if (!i_rst_n) begin
            set_size = 0;
            expected_answers.delete();
            o_outstanding <= 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (expected_answers.size() == 0) begin
                    report_mismatch("result with nothing expected", got, '0);
                end else begin
                    exp = expected_answers.pop_front();
                    bad_fields = "";
                    if (got.ok !== exp.ok)
                        bad_fields = {bad_fields, " ok"};
                    if (got.full_res !== exp.full_res)
                        bad_fields = {bad_fields, " full_res"};
                    if (got.count !== exp.count)
                        bad_fields = {bad_fields, " count"};
                    if (got.empty_res !== exp.empty_res)
                        bad_fields = {bad_fields, " empty_res"};
                    if (bad_fields != "")
                        report_mismatch({"wrong", bad_fields}, got, exp);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_answers.push_back(apply_set_op(
                    i_s_axis_tdata[OP_WIDTH-1:0],
                    i_s_axis_tdata[OP_WIDTH +: VALUE_WIDTH]));
            o_outstanding <= expected_answers.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

// Drives the sorted set table with directed and random operations under random
// flow control; the checker beside the block does the prediction.
module tb_top;
    import sst_pkg::*;

    localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1050;
    localparam int PHASE_ITEMS  = 130;
    localparam int POOL_SIZE    = 24;
    localparam int IDLE_LIMIT   = 2000;

    logic                      clk     = 1'b0;
    logic                      rst_n   = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [IN_DATA_WIDTH-1:0]  s_data  = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_data;
    int                        fail_count;
    int                        outstanding;
    int                        idle_cycles = 0;

    // Values drawn most of the time, so that hits, duplicates and a full table occur.
    t_elem value_pool [POOL_SIZE];

    always #6 clk = ~clk;

    sorted_set_table_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    sorted_set_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // Offer one item and return at the edge where it is accepted.
    task automatic send_item(input logic [OP_WIDTH-1:0] op, input t_elem val);
        s_valid <= 1'b1;
        s_data  <= {{(IN_DATA_WIDTH-OP_WIDTH-VALUE_WIDTH){1'b0}}, val, op};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
    endtask

    // Hold the input idle until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic t_elem pick_value();
        if ($urandom_range(9) == 0)
            return $urandom;
        return value_pool[$urandom_range(POOL_SIZE-1)];
    endfunction

    // The insert share sets whether the table tends to fill up or drain.
    function automatic logic [OP_WIDTH-1:0] pick_op(input int insert_share);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return OP_UNUSED;
        if (r < 3 + insert_share)
            return OP_INSERT;
        if (r < 3 + insert_share + (97 - insert_share) * 2 / 3)
            return OP_REMOVE;
        return OP_SEARCH;
    endfunction

    // Stimulus: reset, directed cases, then phases of random operations in bursts.
    initial begin
        int sent;
        int burst_len;
        int gap;
        int insert_share;
        bit drained_once;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 0;
        value_pool[3] = -1;
        value_pool[4] = 1;
        value_pool[5] = 32'sh8000_0001;
        value_pool[6] = 32'sh7fff_fffe;
        for (int k = 7; k < POOL_SIZE; k++) begin
            if (k % 2 == 0)
                value_pool[k] = $urandom;
            else
                value_pool[k] = value_pool[k-1] + 1;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty table: unused code, search and remove all answer not ok.
        send_item(OP_UNUSED, 0);
        send_item(OP_SEARCH, 5);
        send_item(OP_REMOVE, 5);
        // Extremes, a duplicate, hits and misses.
        send_item(OP_INSERT, 32'sh8000_0000);
        send_item(OP_INSERT, 32'sh7fff_ffff);
        send_item(OP_INSERT, 0);
        send_item(OP_INSERT, 0);
        send_item(OP_SEARCH, 32'sh7fff_ffff);
        send_item(OP_SEARCH, 5);
        send_item(OP_REMOVE, 32'sh8000_0000);
        send_item(OP_REMOVE, 5);
        // Fill the table, then a refused insert and a duplicate into the full table.
        for (int k = 1; k <= CAPACITY - 2; k++)
            send_item(OP_INSERT, k * 1000 - 7500);
        send_item(OP_INSERT, 123);
        send_item(OP_INSERT, 0);
        send_item(OP_SEARCH, 32'sh7fff_ffff);
        wait_drained();

        sent = 0;
        drained_once = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            insert_share = ((sent / PHASE_ITEMS) % 2 == 0) ? 60 : 20;
            burst_len = $urandom_range(1, 24);
            for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
                send_item(pick_op(insert_share), pick_value());
                sent++;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if (!drained_once && sent >= RANDOM_ITEMS / 2) begin
                drained_once = 1'b1;
                wait_drained();
            end
        end

        // Let the last results come out, then a short tail for stray ones.
        wait_drained();
        repeat (12) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: segments of always ready, random, mostly stalled or periodic,
    // with two long hold-offs that back the block up into its input.
    initial begin
        int  mode;
        int  seg_len;
        int  period;
        int  cyc;
        bit  first_hold_done;
        bit  second_hold_done;
        cyc = 0;
        first_hold_done = 1'b0;
        second_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            mode    = $urandom_range(3);
            seg_len = $urandom_range(4, 60);
            period  = $urandom_range(2, 6);
            for (int c = 0; c < seg_len; c++) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(1);
                    2:       m_ready <= ($urandom_range(3) == 0);
                    default: m_ready <= (c % period == 0);
                endcase
                @(posedge clk);
                cyc++;
            end
            if ((!first_hold_done && cyc >= 400) || (!second_hold_done && cyc >= 2500)) begin
                if (first_hold_done)
                    second_hold_done = 1'b1;
                first_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (90) @(posedge clk);
                cyc += 90;
            end
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
+incdir+src
src/sst_pkg.sv
src/sst_ctrl.sv
src/sst_datapath.sv
src/sorted_set_table_top.sv
verif/sorted_set_checker.sv
verif/tb_top.sv
